// ----- rtl/core/lslm_pkg.sv -----
// Package for the link session loss monitor.
// Holds event codes, configuration register indexes and statistics selects.
// No dependencies.
`timescale 1ns / 1ps

package lslm_pkg;

  typedef enum logic [2:0] {
    OP_RX_OK        = 3'd0,
    OP_RX_BAD       = 3'd1,
    OP_TX_SEND      = 3'd2,
    OP_RX_INCOMPL   = 3'd3,
    OP_LISTEN_TMO   = 3'd4,
    OP_TRIG_FAIL    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    CFG_KEEPALIVE_SEQ = 3'd0,
    CFG_KEEPALIVE_LEN = 3'd1,
    CFG_METADATA_LEN  = 3'd2,
    CFG_MAX_LEN       = 3'd3,
    CFG_SYNC_LOSS     = 3'd4,
    CFG_STAT_SELECT   = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    STAT_LOST       = 4'd0,
    STAT_BURST_1    = 4'd1,
    STAT_BURST_2    = 4'd2,
    STAT_BURST_3_4  = 4'd3,
    STAT_BURST_5UP  = 4'd4,
    STAT_LONGEST    = 4'd5,
    STAT_OUTAGE     = 4'd6,
    STAT_INCOMPL    = 4'd7,
    STAT_TRIG_FAIL  = 4'd8
  } stat_sel_e;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned BurstBins    = 4;

  localparam logic [15:0] KeepaliveSeqRst = 16'hFFFF;
  localparam logic [7:0]  KeepaliveLenRst = 8'd3;
  localparam logic [7:0]  MetadataLenRst  = 8'd2;
  localparam logic [7:0]  MaxLenRst       = 8'd255;
  localparam logic [3:0]  SyncLossRst     = 4'd8;

endpackage

// ----- rtl/core/link_session_loss_monitor.sv -----
// Link session loss monitor: top level with input stage, state update and result stage.
// Depends on lslm_pkg.
`timescale 1ns / 1ps

// Usage:
// - Event channel: in_valid_i / in_stall_o with operation_i, packet_length_i,
//   packet_seq_i. An item is taken at an edge with valid high and stall low.
// - Result channel: out_valid_o / out_stall_i, one result item per event.
// - Config channel: cfg_valid_i / cfg_ready_o, cfg_index_i selects the register,
//   cfg_data_i holds the value (low bits used). Ready is always high; write
//   only while no event is in flight.
// - Path: an event taken is held in the input register, and its result is then
//   registered in the output register.
// - Throughput: one event per cycle while the result side does not stall. The
//   session state updates as the item moves from the input register to the output register.
// - Reset clears session state, counters and both stages; config registers
//   return to their defaults.
// - A stall on the result side holds the output register; the input register
//   keeps one more item, and then in_stall_o rises until the output moves.
module link_session_loss_monitor #(
  parameter int unsigned SEQ_WIDTH     = 16,
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  packet_length_i,
  input  logic [15:0] packet_seq_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        in_service_o,
  output logic        length_valid_o,
  output logic        deliver_o,
  output logic [15:0] assigned_tx_seq_o,
  output logic [14:0] gap_found_o,
  output logic        outage_now_o,
  output logic        radio_stop_o,
  output logic [31:0] stat_value_o,

  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lslm_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [lslm_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  localparam int unsigned SW = SEQ_WIDTH;
  localparam int unsigned CW = COUNTER_WIDTH;

  // configuration
  logic [15:0] keepalive_seq_q;
  logic [7:0]  keepalive_len_q;
  logic [7:0]  metadata_len_q;
  logic [7:0]  max_len_q;
  logic [3:0]  sync_loss_q;
  logic [3:0]  stat_select_q;

  // input stage
  logic        s1_valid_q, s1_valid_d;
  logic [2:0]  op_q;
  logic [7:0]  len_q;
  logic [15:0] seq_q;

  // session state
  logic          service_q, service_d;
  logic [3:0]    miss_q, miss_d;
  logic [SW-1:0] last_rx_q, last_rx_d;
  logic          have_last_q, have_last_d;
  logic [SW-1:0] next_tx_q, next_tx_d;
  logic [CW-1:0] lost_q, lost_d;
  logic [CW-1:0] hist_q [lslm_pkg::BurstBins];
  logic [CW-1:0] hist_d [lslm_pkg::BurstBins];
  logic [SW-2:0] longest_q, longest_d;
  logic [CW-1:0] outage_cnt_q, outage_cnt_d;
  logic [CW-1:0] incompl_q, incompl_d;
  logic [CW-1:0] trig_fail_q, trig_fail_d;

  // result stage
  logic        out_valid_q;
  logic        r_service_d, r_lvalid_d, r_deliver_d, r_outage_d, r_stop_d;
  logic [15:0] r_txseq_d;
  logic [14:0] r_gap_d;
  logic [31:0] r_stat_d;
  logic        r_service_q, r_lvalid_q, r_deliver_q, r_outage_q, r_stop_q;
  logic [15:0] r_txseq_q;
  logic [14:0] r_gap_q;
  logic [31:0] r_stat_q;

  logic          s2_ready, s1_fire, in_accept;
  logic          len_ok, ka_hit, loss;
  logic [SW-1:0] ka_seq, seq_m, exp_inc, expect_seq, delta, tx_inc, tx_adv;
  logic [3:0]    miss_inc;
  logic [CW-1:0] stat_sel;

  assign s2_ready    = !out_valid_q || !out_stall_i;
  assign s1_fire     = s1_valid_q && s2_ready;
  assign in_stall_o  = s1_valid_q && !s2_ready;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign len_ok       = (len_q > metadata_len_q) && (len_q <= max_len_q);
  assign ka_hit       = (len_q == keepalive_len_q) && (seq_q == keepalive_seq_q);
  assign ka_seq       = SW'(keepalive_seq_q);
  assign seq_m        = SW'(seq_q);
  assign exp_inc      = last_rx_q + SW'(1);
  assign expect_seq   = (exp_inc == ka_seq) ? exp_inc + SW'(1) : exp_inc;
  assign delta        = seq_m - expect_seq;
  assign loss         = have_last_q && (delta != '0) && !delta[SW-1];
  assign tx_inc       = next_tx_q + SW'(1);
  assign tx_adv       = (tx_inc == ka_seq) ? tx_inc + SW'(1) : tx_inc;
  assign miss_inc     = miss_q + 4'd1;

  always_comb begin
    service_d    = service_q;
    miss_d       = miss_q;
    last_rx_d    = last_rx_q;
    have_last_d  = have_last_q;
    next_tx_d    = next_tx_q;
    lost_d       = lost_q;
    hist_d       = hist_q;
    longest_d    = longest_q;
    outage_cnt_d = outage_cnt_q;
    incompl_d    = incompl_q;
    trig_fail_d  = trig_fail_q;
    r_lvalid_d   = 1'b0;
    r_deliver_d  = 1'b0;
    r_txseq_d    = '0;
    r_gap_d      = '0;
    r_outage_d   = 1'b0;
    r_stop_d     = 1'b0;

    case (lslm_pkg::op_e'(op_q))
      lslm_pkg::OP_RX_OK: begin
        if (len_ok) begin
          r_lvalid_d = 1'b1;
          miss_d     = '0;
          service_d  = 1'b1;
          if (!ka_hit) begin
            r_deliver_d = 1'b1;
            if (loss) begin
              r_gap_d = 15'(delta);
              lost_d  = lost_q + CW'(delta);
              if (delta == SW'(1)) begin
                hist_d[0] = hist_q[0] + CW'(1);
              end else if (delta == SW'(2)) begin
                hist_d[1] = hist_q[1] + CW'(1);
              end else if (delta <= SW'(4)) begin
                hist_d[2] = hist_q[2] + CW'(1);
              end else begin
                hist_d[3] = hist_q[3] + CW'(1);
              end
              if (delta > SW'(longest_q)) begin
                longest_d = delta[SW-2:0];
              end
            end
            last_rx_d   = seq_m;
            have_last_d = 1'b1;
          end
        end
      end
      lslm_pkg::OP_RX_BAD: begin
        miss_d = '0;
      end
      lslm_pkg::OP_TX_SEND: begin
        if (len_ok) begin
          r_lvalid_d = 1'b1;
          r_txseq_d  = 16'(next_tx_q);
          next_tx_d  = tx_adv;
        end
      end
      lslm_pkg::OP_RX_INCOMPL: begin
        incompl_d = incompl_q + CW'(1);
        miss_d    = '0;
      end
      lslm_pkg::OP_LISTEN_TMO: begin
        if (service_q) begin
          miss_d = miss_inc;
          if (miss_inc >= sync_loss_q) begin
            outage_cnt_d = outage_cnt_q + CW'(1);
            r_outage_d   = 1'b1;
            service_d    = 1'b0;
            miss_d       = '0;
            have_last_d  = 1'b0;
          end
        end
      end
      lslm_pkg::OP_TRIG_FAIL: begin
        trig_fail_d = trig_fail_q + CW'(1);
        if (service_q) begin
          outage_cnt_d = outage_cnt_q + CW'(1);
          r_outage_d   = 1'b1;
        end
        service_d   = 1'b0;
        miss_d      = '0;
        have_last_d = 1'b0;
        r_stop_d    = 1'b1;
      end
      default: begin
      end
    endcase

    case (lslm_pkg::stat_sel_e'(stat_select_q))
      lslm_pkg::STAT_LOST:      stat_sel = lost_d;
      lslm_pkg::STAT_BURST_1:   stat_sel = hist_d[0];
      lslm_pkg::STAT_BURST_2:   stat_sel = hist_d[1];
      lslm_pkg::STAT_BURST_3_4: stat_sel = hist_d[2];
      lslm_pkg::STAT_BURST_5UP: stat_sel = hist_d[3];
      lslm_pkg::STAT_LONGEST:   stat_sel = CW'(longest_d);
      lslm_pkg::STAT_OUTAGE:    stat_sel = outage_cnt_d;
      lslm_pkg::STAT_INCOMPL:   stat_sel = incompl_d;
      lslm_pkg::STAT_TRIG_FAIL: stat_sel = trig_fail_d;
      default:                  stat_sel = '0;
    endcase
    r_stat_d    = 32'(stat_sel);
    r_service_d = service_d;
  end

  always_comb begin
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keepalive_seq_q <= lslm_pkg::KeepaliveSeqRst;
      keepalive_len_q <= lslm_pkg::KeepaliveLenRst;
      metadata_len_q  <= lslm_pkg::MetadataLenRst;
      max_len_q       <= lslm_pkg::MaxLenRst;
      sync_loss_q     <= lslm_pkg::SyncLossRst;
      stat_select_q   <= '0;
    end else if (cfg_valid_i) begin
      case (lslm_pkg::cfg_idx_e'(cfg_index_i))
        lslm_pkg::CFG_KEEPALIVE_SEQ: keepalive_seq_q <= cfg_data_i[15:0];
        lslm_pkg::CFG_KEEPALIVE_LEN: keepalive_len_q <= cfg_data_i[7:0];
        lslm_pkg::CFG_METADATA_LEN:  metadata_len_q  <= cfg_data_i[7:0];
        lslm_pkg::CFG_MAX_LEN:       max_len_q       <= cfg_data_i[7:0];
        lslm_pkg::CFG_SYNC_LOSS:     sync_loss_q     <= cfg_data_i[3:0];
        lslm_pkg::CFG_STAT_SELECT:   stat_select_q   <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      service_q    <= 1'b0;
      miss_q       <= '0;
      last_rx_q    <= '0;
      have_last_q  <= 1'b0;
      next_tx_q    <= '0;
      lost_q       <= '0;
      hist_q       <= '{default: '0};
      longest_q    <= '0;
      outage_cnt_q <= '0;
      incompl_q    <= '0;
      trig_fail_q  <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        service_q    <= service_d;
        miss_q       <= miss_d;
        last_rx_q    <= last_rx_d;
        have_last_q  <= have_last_d;
        next_tx_q    <= next_tx_d;
        lost_q       <= lost_d;
        hist_q       <= hist_d;
        longest_q    <= longest_d;
        outage_cnt_q <= outage_cnt_d;
        incompl_q    <= incompl_d;
        trig_fail_q  <= trig_fail_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= operation_i;
      len_q <= packet_length_i;
      seq_q <= packet_seq_i;
    end
    if (s1_fire) begin
      r_service_q <= r_service_d;
      r_lvalid_q  <= r_lvalid_d;
      r_deliver_q <= r_deliver_d;
      r_txseq_q   <= r_txseq_d;
      r_gap_q     <= r_gap_d;
      r_outage_q  <= r_outage_d;
      r_stop_q    <= r_stop_d;
      r_stat_q    <= r_stat_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign in_service_o      = r_service_q;
  assign length_valid_o    = r_lvalid_q;
  assign deliver_o         = r_deliver_q;
  assign assigned_tx_seq_o = r_txseq_q;
  assign gap_found_o       = r_gap_q;
  assign outage_now_o      = r_outage_q;
  assign radio_stop_o      = r_stop_q;
  assign stat_value_o      = r_stat_q;

endmodule

// ----- rtl/core/lslm_checker.sv -----
// Port-level checker for the link session loss monitor and its bind.
// Depends on link_session_loss_monitor.
`timescale 1ns / 1ps

module lslm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        in_service_o,
  input logic        length_valid_o,
  input logic        deliver_o,
  input logic [14:0] gap_found_o,
  input logic        outage_now_o,
  input logic        radio_stop_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output stage empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outage_now_o || radio_stop_o) |-> !in_service_o)
    else $error("service still up after outage or radio stop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && deliver_o |-> length_valid_o && in_service_o)
    else $error("delivered item without valid length or service");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (gap_found_o != '0) |-> deliver_o)
    else $error("gap reported on a non-delivered item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

bind link_session_loss_monitor lslm_checker u_lslm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .in_service_o   (in_service_o),
  .length_valid_o (length_valid_o),
  .deliver_o      (deliver_o),
  .gap_found_o    (gap_found_o),
  .outage_now_o   (outage_now_o),
  .radio_stop_o   (radio_stop_o)
);
